// File: sv/lfps_pkg.sv
// Shared constants, types and the sensor pattern table for the line-follow steering core.
`default_nettype none
package lfps_pkg;

  localparam int SENSOR_COUNT = 6;
  localparam int GAIN_W       = 8;
  localparam int DRIVE_W      = 8;
  localparam int ERR_W        = 5;
  localparam int SUM_W        = 16;
  localparam int CORR_W       = 24;
  localparam int CLASS_W      = 2;
  localparam int CFG_IDX_W    = 3;

  localparam logic [SENSOR_COUNT-1:0] ALL_WHITE = '0;
  localparam logic [SENSOR_COUNT-1:0] ALL_BLACK = '1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM  = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_P_RESET     = 8'd5;
  localparam logic [GAIN_W-1:0]  GAIN_I_RESET     = 8'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RESET     = 8'd2;
  localparam logic [DRIVE_W-1:0] BASE_SPEED_RESET = 8'd100;
  localparam logic [DRIVE_W-1:0] LEFT_TRIM_RESET  = 8'd5;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = '1;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_LISTED   = 2'd0,
    CLASS_UNLISTED = 2'd1,
    CLASS_WHITE    = 2'd2,
    CLASS_BLACK    = 2'd3
  } pattern_class_t;

  typedef struct packed {
    logic                    hit;
    logic signed [ERR_W-1:0] err;
  } lookup_t;

  function automatic lookup_t pattern_lookup(input logic [SENSOR_COUNT-1:0] pat);
    lookup_t r;
    r.hit = 1'b1;
    r.err = '0;
    unique case (pat)
      6'b111110, 6'b111100, 6'b111000: r.err = -5'sd15;
      6'b100000:                       r.err = -5'sd5;
      6'b110000:                       r.err = -5'sd4;
      6'b010000:                       r.err = -5'sd3;
      6'b011000:                       r.err = -5'sd2;
      6'b001000:                       r.err = -5'sd1;
      6'b001100:                       r.err = 5'sd0;
      6'b000100:                       r.err = 5'sd1;
      6'b000110:                       r.err = 5'sd2;
      6'b000010:                       r.err = 5'sd3;
      6'b000011:                       r.err = 5'sd4;
      6'b000001:                       r.err = 5'sd5;
      6'b000111, 6'b001111, 6'b011111: r.err = 5'sd15;
      default:                         r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/line_follow_pid_steering_core.sv
// Top level: sensor pattern to PID wheel drives, one input register and one result register.
//
//  channel  handshake              payload
//  -------  ---------------------  -------------------------------------------------
//  in       in_valid / in_ready    sensor_bits
//  out      out_valid / out_ready  left_drive right_drive line_error correction
//                                  pattern_class drive_updated
//  cfg      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One transaction per cycle sustained while out_ready stays high; an input passes through the
// input register and then the result register. The loop through error_sum and previous_error
// closes combinationally between the input register and the state registers.
// Reset restores the register defaults and clears state and both valid stages.
// A stalled result holds the input stage once it is full; cfg_ready is always high.
`default_nettype none
module line_follow_pid_steering_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [lfps_pkg::SENSOR_COUNT-1:0]    sensor_bits,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [lfps_pkg::DRIVE_W-1:0]              left_drive,
  output logic [lfps_pkg::DRIVE_W-1:0]              right_drive,
  output logic signed [lfps_pkg::ERR_W-1:0]         line_error,
  output logic signed [lfps_pkg::CORR_W-1:0]        correction,
  output logic [lfps_pkg::CLASS_W-1:0]              pattern_class,
  output logic                                      drive_updated,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lfps_pkg::GAIN_W-1:0]          cfg_data
);
  import lfps_pkg::*;

  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [DRIVE_W-1:0] base_speed;
  logic [DRIVE_W-1:0] left_trim;

  logic                     stage_valid;
  logic [SENSOR_COUNT-1:0]  stage_bits;

  logic signed [ERR_W-1:0]  previous_error;
  logic signed [SUM_W-1:0]  error_sum;
  logic [DRIVE_W-1:0]       held_left;
  logic [DRIVE_W-1:0]       held_right;
  logic signed [CORR_W-1:0] held_correction;

  logic                     advance;
  logic                     hold_case;
  lookup_t                  lk;
  logic signed [ERR_W-1:0]  err_cur;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [ERR_W:0]    delta;
  logic signed [13:0]       p_term;
  logic signed [24:0]       i_term;
  logic signed [14:0]       d_term;
  logic signed [25:0]       pid_wide;
  logic signed [CORR_W-1:0] pid_sat;
  logic signed [25:0]       left_raw;
  logic signed [25:0]       right_raw;
  logic [DRIVE_W-1:0]       left_clamp;
  logic [DRIVE_W-1:0]       right_clamp;
  logic [DRIVE_W:0]         left_trimmed;
  logic [DRIVE_W-1:0]       left_next;
  pattern_class_t           class_next;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= GAIN_P_RESET;
      gain_i     <= GAIN_I_RESET;
      gain_d     <= GAIN_D_RESET;
      base_speed <= BASE_SPEED_RESET;
      left_trim  <= LEFT_TRIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:     gain_p     <= cfg_data;
        REG_GAIN_I:     gain_i     <= cfg_data;
        REG_GAIN_D:     gain_d     <= cfg_data;
        REG_BASE_SPEED: base_speed <= cfg_data;
        REG_LEFT_TRIM:  left_trim  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hold_case = (stage_bits == ALL_WHITE) || (stage_bits == ALL_BLACK);
    lk        = pattern_lookup(stage_bits);
    err_cur   = lk.hit ? lk.err : previous_error;

    sum_wide = {error_sum[SUM_W-1], error_sum} + {{(SUM_W+1-ERR_W){err_cur[ERR_W-1]}}, err_cur};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end

    delta  = {err_cur[ERR_W-1], err_cur} - {previous_error[ERR_W-1], previous_error};
    p_term = $signed({6'd0, gain_p}) * $signed({{9{err_cur[ERR_W-1]}}, err_cur});
    i_term = $signed({17'd0, gain_i}) * $signed({{9{sum_next[SUM_W-1]}}, sum_next});
    d_term = $signed({7'd0, gain_d}) * $signed({{9{delta[ERR_W]}}, delta});

    pid_wide = {{12{p_term[13]}}, p_term} + {i_term[24], i_term} + {{11{d_term[14]}}, d_term};
    if (pid_wide[25:23] != 3'b000 && pid_wide[25:23] != 3'b111) begin
      pid_sat = pid_wide[25] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      pid_sat = pid_wide[CORR_W-1:0];
    end

    left_raw  = $signed({18'd0, base_speed}) + {{2{pid_sat[CORR_W-1]}}, pid_sat};
    right_raw = $signed({18'd0, base_speed}) - {{2{pid_sat[CORR_W-1]}}, pid_sat};

    priority if (left_raw[25]) begin
      left_clamp = '0;
    end else if (left_raw[24:DRIVE_W] != '0) begin
      left_clamp = DRIVE_MAX;
    end else begin
      left_clamp = left_raw[DRIVE_W-1:0];
    end

    priority if (right_raw[25]) begin
      right_clamp = '0;
    end else if (right_raw[24:DRIVE_W] != '0) begin
      right_clamp = DRIVE_MAX;
    end else begin
      right_clamp = right_raw[DRIVE_W-1:0];
    end

    left_trimmed = {1'b0, left_clamp} + {1'b0, left_trim};
    left_next    = left_trimmed[DRIVE_W] ? DRIVE_MAX : left_trimmed[DRIVE_W-1:0];

    priority if (stage_bits == ALL_WHITE) begin
      class_next = CLASS_WHITE;
    end else if (stage_bits == ALL_BLACK) begin
      class_next = CLASS_BLACK;
    end else if (lk.hit) begin
      class_next = CLASS_LISTED;
    end else begin
      class_next = CLASS_UNLISTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_bits <= sensor_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error  <= '0;
      error_sum       <= '0;
      held_left       <= '0;
      held_right      <= '0;
      held_correction <= '0;
    end else if (advance && !hold_case) begin
      previous_error  <= err_cur;
      error_sum       <= sum_next;
      held_left       <= left_next;
      held_right      <= right_clamp;
      held_correction <= pid_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pattern_class <= class_next;
      if (hold_case) begin
        left_drive    <= held_left;
        right_drive   <= held_right;
        line_error    <= previous_error;
        correction    <= held_correction;
        drive_updated <= 1'b0;
      end else begin
        left_drive    <= left_next;
        right_drive   <= right_clamp;
        line_error    <= err_cur;
        correction    <= pid_sat;
        drive_updated <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
